// ===== design/dnps_pkg.sv =====
// Day/night pixel shader package: shared constants, register and zone codes,
// transaction and configuration structs.
// No dependencies.
package dnps_pkg;

  localparam int DEF_FRACTION_BITS = 14;
  localparam int DEF_PIXEL_WIDTH   = 32;
  localparam int DUSK_SLOPE        = 1920;
  localparam int LEVEL_BASE        = 64;
  localparam int NIGHT_LEVEL       = 64;
  localparam int PIPE_LATENCY      = 6;
  localparam int CFG_ADDR_W        = 5;
  localparam int CFG_DATA_W        = 32;

  typedef enum logic [2:0] {
    REG_SUN_X          = 3'd0,
    REG_SUN_Y          = 3'd1,
    REG_SUN_Z          = 3'd2,
    REG_CHANNEL_SHIFTS = 3'd3,
    REG_CHANNEL_WIDTHS = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ZONE_NIGHT = 2'd0,
    ZONE_DUSK  = 2'd1,
    ZONE_DAY   = 2'd2
  } zone_t;

  typedef struct packed {
    logic        [31:0] source_pixel;
    logic signed [15:0] column_sine;
    logic signed [15:0] column_cosine;
    logic signed [15:0] row_sine;
    logic signed [15:0] row_cosine;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  zone;
    logic [31:0] raw_pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] sun_x;
    logic signed [15:0] sun_y;
    logic signed [15:0] sun_z;
    logic        [14:0] channel_shifts;
    logic        [11:0] channel_widths;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    zone_t zone;
  } stage_ctrl_t;

  localparam cfg_t CFG_RESET = '{
    sun_x:          16'sd0,
    sun_y:          16'sd16384,
    sun_z:          16'sd0,
    channel_shifts: 15'd10272,
    channel_widths: 12'd2184
  };

endpackage

// ===== design/dnps_cfg_regs.sv =====
// Day/night pixel shader configuration registers behind an APB-style port.
// Depends on dnps_pkg.
module dnps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dnps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dnps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dnps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output dnps_pkg::cfg_t                  cfg
);
  import dnps_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SUN_X:          cfg_nxt.sun_x          = pwdata[15:0];
        REG_SUN_Y:          cfg_nxt.sun_y          = pwdata[15:0];
        REG_SUN_Z:          cfg_nxt.sun_z          = pwdata[15:0];
        REG_CHANNEL_SHIFTS: cfg_nxt.channel_shifts = pwdata[14:0];
        REG_CHANNEL_WIDTHS: cfg_nxt.channel_widths = pwdata[11:0];
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SUN_X:          prdata = {16'b0, cfg_r.sun_x};
      REG_SUN_Y:          prdata = {16'b0, cfg_r.sun_y};
      REG_SUN_Z:          prdata = {16'b0, cfg_r.sun_z};
      REG_CHANNEL_SHIFTS: prdata = {17'b0, cfg_r.channel_shifts};
      REG_CHANNEL_WIDTHS: prdata = {20'b0, cfg_r.channel_widths};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/dnps_light.sv =====
// Day/night pixel shader illumination pipeline: dot product with the sun
// direction, floor to fixed point, zone decision and dusk offset.
// Depends on dnps_pkg.
module dnps_light #(
  parameter int FRACTION_BITS = dnps_pkg::DEF_FRACTION_BITS,
  parameter int PIXEL_WIDTH   = dnps_pkg::DEF_PIXEL_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  dnps_pkg::in_item_t         in_item,
  input  dnps_pkg::cfg_t             cfg,
  output dnps_pkg::stage_ctrl_t      out_ctrl,
  output logic [PIXEL_WIDTH-1:0]     out_pixel,
  output logic [FRACTION_BITS-1:0]   out_dusk
);
  import dnps_pkg::*;

  localparam int PROD_W    = 32;
  localparam int TRIPLE_W  = 48;
  localparam int SUM_W     = ((PROD_W + FRACTION_BITS) > TRIPLE_W ?
                              (PROD_W + FRACTION_BITS) : TRIPLE_W) + 2;
  localparam int LIGHT_W   = SUM_W - 2 * FRACTION_BITS;
  localparam int CMP_W     = (LIGHT_W > FRACTION_BITS + 2) ? LIGHT_W : FRACTION_BITS + 2;
  localparam int DUSK_EDGE = (1 << FRACTION_BITS) / 20;
  localparam logic signed [CMP_W-1:0] EDGE = CMP_W'(DUSK_EDGE);

  logic signed [15:0]         cs;
  logic signed [15:0]         cc;
  logic signed [15:0]         rs;
  logic signed [15:0]         sx;
  logic signed [15:0]         sy;
  logic signed [15:0]         sz;

  logic                       s1_valid_r;
  logic [PIXEL_WIDTH-1:0]     s1_pixel_r;
  logic signed [PROD_W-1:0]   s1_x_r;
  logic signed [PROD_W-1:0]   s1_y_r;
  logic signed [PROD_W-1:0]   s1_z_r;
  logic signed [15:0]         s1_rc_r;

  logic                       s2_valid_r;
  logic [PIXEL_WIDTH-1:0]     s2_pixel_r;
  logic signed [TRIPLE_W-1:0] s2_x_r;
  logic signed [TRIPLE_W-1:0] s2_z_r;
  logic signed [PROD_W-1:0]   s2_y_r;

  logic                       s3_valid_r;
  logic [PIXEL_WIDTH-1:0]     s3_pixel_r;
  logic signed [SUM_W-1:0]    s3_sum_r;
  logic signed [SUM_W-1:0]    s3_sum_nxt;

  logic signed [LIGHT_W-1:0]  light;
  logic signed [CMP_W-1:0]    light_x;
  stage_ctrl_t                ctrl_r;
  stage_ctrl_t                ctrl_nxt;
  logic [PIXEL_WIDTH-1:0]     pixel_r;
  logic [FRACTION_BITS-1:0]   dusk_r;
  logic [FRACTION_BITS-1:0]   dusk_nxt;

  assign cs = in_item.column_sine;
  assign cc = in_item.column_cosine;
  assign rs = in_item.row_sine;
  assign sx = cfg.sun_x;
  assign sy = cfg.sun_y;
  assign sz = cfg.sun_z;

  assign s3_sum_nxt = SUM_W'(s2_x_r) + SUM_W'(s2_z_r)
                    + (SUM_W'(s2_y_r) <<< FRACTION_BITS);

  assign light   = LIGHT_W'(s3_sum_r >>> (2 * FRACTION_BITS));
  assign light_x = CMP_W'(light);

  always_comb begin
    ctrl_nxt.valid = s3_valid_r;
    dusk_nxt       = FRACTION_BITS'(light_x + EDGE);
    priority if (light_x < -EDGE) begin
      ctrl_nxt.zone = ZONE_NIGHT;
    end else if (light_x > EDGE) begin
      ctrl_nxt.zone = ZONE_DAY;
    end else begin
      ctrl_nxt.zone = ZONE_DUSK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      ctrl_r     <= '{valid: 1'b0, zone: ZONE_NIGHT};
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      ctrl_r     <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pixel_r <= in_item.source_pixel[PIXEL_WIDTH-1:0];
    s1_x_r     <= sx * cc;
    s1_y_r     <= sy * rs;
    s1_z_r     <= sz * cs;
    s1_rc_r    <= in_item.row_cosine;
    s2_pixel_r <= s1_pixel_r;
    s2_x_r     <= s1_x_r * s1_rc_r;
    s2_z_r     <= s1_z_r * s1_rc_r;
    s2_y_r     <= s1_y_r;
    s3_pixel_r <= s2_pixel_r;
    s3_sum_r   <= s3_sum_nxt;
    pixel_r    <= s3_pixel_r;
    dusk_r     <= dusk_nxt;
  end

  assign out_ctrl  = ctrl_r;
  assign out_pixel = pixel_r;
  assign out_dusk  = dusk_r;

endmodule

// ===== design/dnps_shade.sv =====
// Day/night pixel shader shading stages: channel unpack, intensity level,
// per-channel scaling and the result register.
// Depends on dnps_pkg.
module dnps_shade #(
  parameter int FRACTION_BITS = dnps_pkg::DEF_FRACTION_BITS,
  parameter int PIXEL_WIDTH   = dnps_pkg::DEF_PIXEL_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dnps_pkg::stage_ctrl_t      in_ctrl,
  input  logic [PIXEL_WIDTH-1:0]     in_pixel,
  input  logic [FRACTION_BITS-1:0]   in_dusk,
  input  dnps_pkg::cfg_t             cfg,
  output logic                       out_valid,
  output dnps_pkg::out_item_t        out_item
);
  import dnps_pkg::*;

  localparam int RAMP_W = FRACTION_BITS + 11;

  function automatic logic [7:0] channel_byte(input logic [PIXEL_WIDTH-1:0] pixel,
                                              input logic [4:0] pos,
                                              input logic [3:0] width);
    logic [PIXEL_WIDTH-1:0] shifted;
    logic [3:0]             w;
    logic [7:0]             mask;
    begin
      w       = (width > 4'd8) ? 4'd8 : width;
      shifted = pixel >> pos;
      mask    = 8'hFF >> (4'd8 - w);
      return (shifted[7:0] & mask) << (4'd8 - w);
    end
  endfunction

  logic [RAMP_W-1:0]      ramp;
  logic [7:0]             k_nxt;
  logic [7:0]             ch_nxt [3];

  stage_ctrl_t            s5_ctrl_r;
  logic [PIXEL_WIDTH-1:0] s5_pixel_r;
  logic [7:0]             s5_k_r;
  logic [7:0]             s5_ch_r [3];

  logic [15:0]            prod [3];
  logic [7:0]             byte_nxt [3];
  logic                   valid_r;
  out_item_t              item_r;
  out_item_t              item_nxt;

  assign ramp = RAMP_W'(in_dusk) * RAMP_W'(DUSK_SLOPE);

  always_comb begin
    priority if (in_ctrl.zone == ZONE_NIGHT) begin
      k_nxt = 8'(NIGHT_LEVEL);
    end else begin
      k_nxt = 8'(ramp >> FRACTION_BITS) + 8'(LEVEL_BASE);
    end
    for (int i = 0; i < 3; i++) begin
      ch_nxt[i] = channel_byte(in_pixel, cfg.channel_shifts[5*i +: 5],
                               cfg.channel_widths[4*i +: 4]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]     = 16'(s5_ch_r[i]) * 16'(s5_k_r);
      byte_nxt[i] = (s5_ctrl_r.zone == ZONE_DAY) ? 8'd0 : prod[i][15:8];
    end
    item_nxt.zone      = s5_ctrl_r.zone;
    item_nxt.raw_pixel = 32'(s5_pixel_r);
    item_nxt.red       = byte_nxt[0];
    item_nxt.green     = byte_nxt[1];
    item_nxt.blue      = byte_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctrl_r <= '{valid: 1'b0, zone: ZONE_NIGHT};
      valid_r   <= 1'b0;
    end else begin
      s5_ctrl_r <= in_ctrl;
      valid_r   <= s5_ctrl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_pixel_r <= in_pixel;
    s5_k_r     <= k_nxt;
    s5_ch_r    <= ch_nxt;
    item_r     <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== design/day_night_pixel_shader.sv =====
// Day/night pixel shader top level: configuration registers, illumination
// pipeline and shading stages. Depends on dnps_pkg, dnps_cfg_regs,
// dnps_light and dnps_shade.
//
// Usage:
//   Input: drive in_data with a source pixel and the sine/cosine of its
//   column and row angles and raise start; the transaction is taken at each
//   clock edge where start is high and busy is low. busy stays low, so a
//   new transaction may be issued every cycle.
//   Output: each transaction yields one result on out_data, marked by
//   out_valid for exactly one cycle once it leaves the pipeline. The
//   receiver cannot hold results off and needs none: the pipeline moves
//   every cycle and sustains one pixel per clock.
//   The pipeline has six register stages: two multiplier stages, the
//   sum, the zone decision, the unpack/level stage and the result register.
//   Configuration: APB-style, one 32-bit register per word; write only
//   while no transaction is in flight. pready is always high.
//   Reset (rst_n low, synchronous) clears all pipeline valid bits, so
//   transactions in flight are dropped, and loads register defaults.
module day_night_pixel_shader #(
  parameter int FRACTION_BITS = dnps_pkg::DEF_FRACTION_BITS,
  parameter int PIXEL_WIDTH   = dnps_pkg::DEF_PIXEL_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dnps_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output dnps_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dnps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dnps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dnps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dnps_pkg::*;

  cfg_t                     cfg;
  stage_ctrl_t              light_ctrl;
  logic [PIXEL_WIDTH-1:0]   light_pixel;
  logic [FRACTION_BITS-1:0] light_dusk;
  logic                     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dnps_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dnps_light #(
    .FRACTION_BITS (FRACTION_BITS),
    .PIXEL_WIDTH   (PIXEL_WIDTH)
  ) u_light (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (in_data),
    .cfg       (cfg),
    .out_ctrl  (light_ctrl),
    .out_pixel (light_pixel),
    .out_dusk  (light_dusk)
  );

  dnps_shade #(
    .FRACTION_BITS (FRACTION_BITS),
    .PIXEL_WIDTH   (PIXEL_WIDTH)
  ) u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctrl   (light_ctrl),
    .in_pixel  (light_pixel),
    .in_dusk   (light_dusk),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

// ===== design/dnps_checker.sv =====
// Day/night pixel shader port checker and its bind to the top level.
// Depends on dnps_pkg and day_night_pixel_shader.
module dnps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input dnps_pkg::in_item_t  in_data,
  input logic                out_valid,
  input dnps_pkg::out_item_t out_data
);
  import dnps_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without a transaction");

  a_pixel_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.raw_pixel[15:0] == $past(in_data.source_pixel[15:0], PIPE_LATENCY))
    else $error("raw pixel does not match its transaction");

  a_day_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zone == ZONE_DAY) |->
      (out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0))
    else $error("day result carries shaded bytes");

  a_night_dim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zone == ZONE_NIGHT) |->
      (out_data.red[7:6] == 2'b0 && out_data.green[7:6] == 2'b0
       && out_data.blue[7:6] == 2'b0))
    else $error("night byte above quarter level");

endmodule

bind day_night_pixel_shader dnps_checker u_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for day_night_pixel_shader: directed and random pixels across several
// register settings, with shaded results checked against an in-bench predictor.
// Depends on dnps_pkg and the day_night_pixel_shader RTL.
module tb_top;
  import dnps_pkg::*;

  localparam int FRAC      = DEF_FRACTION_BITS;
  localparam int DUSK_EDGE = (1 << FRAC) / 20;
  localparam int LIMIT     = 300000;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  in_item_t  pixel_queue[$];
  out_item_t shade_expect[$];
  out_item_t shade_want;
  cfg_t      shade_cfg = CFG_RESET;
  int        err_count = 0;
  int        cycle_count = 0;
  int        burst_left = 8;
  int        gap_left = 0;

  day_night_pixel_shader dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_item_t predict_shade(in_item_t px, cfg_t c);
    longint      sum;
    longint      light;
    int unsigned lvl;
    int unsigned pos;
    int unsigned w;
    int unsigned cb;
    logic [7:0]  shade [3];
    out_item_t   r;
    int          i;
    sum = longint'(c.sun_x) * longint'(px.column_cosine) * longint'(px.row_cosine)
        + longint'(c.sun_y) * longint'(px.row_sine) * (longint'(1) <<< FRAC)
        + longint'(c.sun_z) * longint'(px.column_sine) * longint'(px.row_cosine);
    light = sum >>> (2 * FRAC);
    if (light < -DUSK_EDGE) begin
      r.zone = ZONE_NIGHT;
      lvl = NIGHT_LEVEL;
    end else if (light > DUSK_EDGE) begin
      r.zone = ZONE_DAY;
      lvl = 0;
    end else begin
      r.zone = ZONE_DUSK;
      lvl = int'(((light + DUSK_EDGE) * DUSK_SLOPE) >>> FRAC) + LEVEL_BASE;
    end
    for (i = 0; i < 3; i++) begin
      pos = 32'(c.channel_shifts[5*i +: 5]);
      w = 32'(c.channel_widths[4*i +: 4]);
      if (w > 8) w = 8;
      if (w == 0 || r.zone == ZONE_DAY) begin
        shade[i] = 8'd0;
      end else begin
        cb = (px.source_pixel >> pos) & ((32'd1 << w) - 1);
        cb = cb << (8 - w);
        shade[i] = 8'((cb * lvl) >> 8);
      end
    end
    r.raw_pixel = px.source_pixel;
    r.red = shade[0];
    r.green = shade[1];
    r.blue = shade[2];
    return r;
  endfunction

  function automatic logic [15:0] trig_value(int span);
    return 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  function automatic logic [15:0] random_sun();
    logic [15:0] ends [5] = '{16'h8000, 16'hC000, 16'h0000, 16'h4000, 16'h7FFF};
    case ($urandom_range(0, 2))
      0: return ends[$urandom_range(0, 4)];
      1: return trig_value(16384);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   i;
    c.sun_x = random_sun();
    c.sun_y = random_sun();
    c.sun_z = random_sun();
    c.channel_shifts = 15'($urandom());
    if ($urandom_range(0, 1) == 0) begin
      c.channel_widths = 12'($urandom());
    end else begin
      for (i = 0; i < 3; i++) c.channel_widths[4*i +: 4] = 4'($urandom_range(1, 8));
    end
    return c;
  endfunction

  function automatic in_item_t random_pixel();
    in_item_t p;
    int       mode;
    mode = $urandom_range(0, 9);
    p.source_pixel = $urandom();
    if ($urandom_range(0, 15) == 0) p.source_pixel = $urandom_range(0, 1) ? '1 : '0;
    p.column_sine = trig_value(16384);
    p.column_cosine = trig_value(16384);
    p.row_sine = trig_value(16384);
    p.row_cosine = trig_value(16384);
    if (mode < 4) begin
      p.row_sine = trig_value(700);
      p.row_cosine = trig_value(700);
    end else if (mode >= 8) begin
      p.column_sine = 16'($urandom());
      p.column_cosine = 16'($urandom());
      p.row_sine = 16'($urandom());
      p.row_cosine = 16'($urandom());
    end
    return p;
  endfunction

  task automatic queue_pixel(logic [31:0] px, int cs, int cc, int rs, int rc);
    in_item_t p;
    p.source_pixel = px;
    p.column_sine = 16'(cs);
    p.column_cosine = 16'(cc);
    p.row_sine = 16'(rs);
    p.row_cosine = 16'(rc);
    pixel_queue.push_back(p);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < 50) $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SUN_X:          shade_cfg.sun_x = data[15:0];
      REG_SUN_Y:          shade_cfg.sun_y = data[15:0];
      REG_SUN_Z:          shade_cfg.sun_z = data[15:0];
      REG_CHANNEL_SHIFTS: shade_cfg.channel_shifts = data[14:0];
      REG_CHANNEL_WIDTHS: shade_cfg.channel_widths = data[11:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_cfg(cfg_t c);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_SUN_X, {junk[31:16], c.sun_x});
    junk = $urandom();
    write_reg(REG_SUN_Y, {junk[31:16], c.sun_y});
    junk = $urandom();
    write_reg(REG_SUN_Z, {junk[31:16], c.sun_z});
    junk = $urandom();
    write_reg(REG_CHANNEL_SHIFTS, {junk[31:15], c.channel_shifts});
    junk = $urandom();
    write_reg(REG_CHANNEL_WIDTHS, {junk[31:12], c.channel_widths});
  endtask

  // hold until every pending transaction has been shaded and checked
  task automatic drain();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || start || shade_expect.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) shade_expect.push_back(predict_shade(in_data, shade_cfg));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          start <= 1'b1;
          in_data <= pixel_queue.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (shade_expect.size() == 0) begin
        report_mismatch("unexpected result", out_data.raw_pixel, 32'd0);
      end else begin
        shade_want = shade_expect.pop_front();
        if (out_data.zone !== shade_want.zone)
          report_mismatch("zone", 32'(out_data.zone), 32'(shade_want.zone));
        if (out_data.raw_pixel !== shade_want.raw_pixel)
          report_mismatch("raw_pixel", out_data.raw_pixel, shade_want.raw_pixel);
        if (out_data.red !== shade_want.red)
          report_mismatch("red", 32'(out_data.red), 32'(shade_want.red));
        if (out_data.green !== shade_want.green)
          report_mismatch("green", 32'(out_data.green), 32'(shade_want.green));
        if (out_data.blue !== shade_want.blue)
          report_mismatch("blue", 32'(out_data.blue), 32'(shade_want.blue));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t phase_cfg;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sun straight overhead: light follows row_sine
    queue_pixel(32'h00000000, 0, 16384, -16384, 16384);
    queue_pixel(32'hFFFFFFFF, -16384, -16384, -820, -16384);
    queue_pixel(32'hA5A5A5A5, 16384, 0, -819, 0);
    queue_pixel(32'h5A5A5A5A, 0, 0, 0, 0);
    queue_pixel(32'hFFFFFFFF, 32767, -32768, 819, 32767);
    queue_pixel(32'h12345678, 0, 0, 820, 0);
    queue_pixel(32'hFFFFFFFF, 0, 0, 16384, 0);
    queue_pixel(32'h80000001, -32768, 32767, 32767, -32768);
    queue_pixel(32'h7FFFFFFF, 0, 0, -32768, 0);
    drain();

    // red and blue reach past the pixel, green has no bits, blue width above eight
    phase_cfg = '{-16'sd16384, 16'sd0, 16'sd16384, {5'd31, 5'd0, 5'd28}, {4'hF, 4'h0, 4'h8}};
    apply_cfg(phase_cfg);
    queue_pixel(32'hFFFFFFFF, 0, 16384, 0, 16384);
    queue_pixel(32'hF0F0F0F0, 16384, 0, 0, 16384);
    queue_pixel(32'hFFFFFFFF, 0, -16384, 0, 16384);
    queue_pixel(32'h0F0F0F0F, 16384, -16384, 32767, 0);
    queue_pixel(32'hFFFFFFFF, 0, 16384, 0, -819);
    queue_pixel(32'hAAAAAAAA, 0, 16384, 0, -820);
    queue_pixel(32'hFFFFFFFF, 0, 16384, 0, 819);
    queue_pixel(32'h55555555, 0, 16384, 0, 820);
    queue_pixel(32'hFFFFFFFF, 32767, -32768, -32768, -32768);
    queue_pixel(32'hC3C3C3C3, -32768, 32767, 0, 32767);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: phase_cfg = '{16'sd16384, 16'sd16384, 16'sd16384, 15'h7FFF, 12'hFFF};
        1: phase_cfg = '{-16'sd16384, -16'sd16384, -16'sd16384, 15'h0000, 12'h111};
        2: phase_cfg = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 15'($urandom()), 12'($urandom())};
        3: phase_cfg = CFG_RESET;
        default: phase_cfg = random_cfg();
      endcase
      apply_cfg(phase_cfg);
      for (int n = 0; n < 175; n++) pixel_queue.push_back(random_pixel());
      drain();
    end

    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
